// ===== rtl/sse_pkg.sv =====
// Shared types, constants and helper functions for the string escape encoder.
`timescale 1ns / 1ps
`default_nettype none
package sse_pkg;

    // Depth of the work queue between the decoder and the expander.
    localparam int QUEUE_DEPTH = 4;

    // Width of a gathered codepoint.
    localparam int CODE_W = 21;

    // Codepoint written for any malformed or truncated sequence ('?').
    localparam logic [CODE_W-1:0] QMARK_CODE = 21'h00003F;

    // Kinds of work handed from the decoder to the expander.
    localparam logic [1:0] JOB_CHAR = 2'd0;  // one byte as it is
    localparam logic [1:0] JOB_PAIR = 2'd1;  // backslash plus letter
    localparam logic [1:0] JOB_CODE = 2'd2;  // \u plus 4 to 6 hex digits

    // Fixed characters of the output.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // UTF-8 byte classes.
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    // One unit of work: what to print for one input byte.
    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] data;
        logic              last;   // word closes the text
    } sse_job_t;

    // Letter that follows the backslash for a short escape, zero if none.
    function automatic logic [7:0] escape_letter(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h00: r = 8'h30;  // '0'
            8'h07: r = 8'h61;  // 'a'
            8'h08: r = 8'h62;  // 'b'
            8'h0C: r = 8'h66;  // 'f'
            8'h0A: r = 8'h6E;  // 'n'
            8'h0D: r = 8'h72;  // 'r'
            8'h09: r = 8'h74;  // 't'
            8'h0B: r = 8'h76;  // 'v'
            8'h27: r = 8'h27;
            8'h22: r = 8'h22;
            8'h5C: r = 8'h5C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Upper-case hex digit.
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = 8'h30 + {4'h0, n};
        end else begin
            r = 8'h37 + {4'h0, n};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sse_front.sv =====
// UTF-8 decoder and byte classifier: turns each input word into queue work.
`timescale 1ns / 1ps
`default_nettype none
module sse_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_fire,
    input  wire [7:0]            text_byte,
    input  wire                  text_last,
    output logic                 push,
    output sse_pkg::sse_job_t    job
);
    import sse_pkg::*;

    logic [1:0]        cont_reg,  cont_next;
    logic [CODE_W-1:0] accum_reg, accum_next;
    logic              ok_reg,    ok_next;

    logic [7:0]        letter;
    logic              emit;

    // Decode one byte against the open sequence
    always_comb begin
        cont_next  = cont_reg;
        accum_next = accum_reg;
        ok_next    = ok_reg;
        emit       = 1'b0;
        job.kind   = JOB_CODE;
        job.data   = QMARK_CODE;
        job.last   = text_last;
        letter     = escape_letter(text_byte);

        if (cont_reg != 2'd0) begin
            // continuation byte of an open sequence
            ok_next    = ok_reg & ((text_byte & CONT_MASK) == CONT_TAG);
            accum_next = {accum_reg[CODE_W-7:0], text_byte[5:0]};
            cont_next  = cont_reg - 2'd1;
            if (cont_next == 2'd0) begin
                emit     = 1'b1;
                job.data = ok_next ? accum_next : QMARK_CODE;
            end else if (text_last) begin
                emit = 1'b1;
            end
        end else if (letter != 8'h00) begin
            emit     = 1'b1;
            job.kind = JOB_PAIR;
            job.data = {{(CODE_W-8){1'b0}}, letter};
        end else if (text_byte >= 8'h20 && text_byte < 8'h7F) begin
            emit     = 1'b1;
            job.kind = JOB_CHAR;
            job.data = {{(CODE_W-8){1'b0}}, text_byte};
        end else if (!text_byte[7]) begin
            // other control bytes
            emit     = 1'b1;
            job.data = {{(CODE_W-8){1'b0}}, text_byte};
        end else begin
            ok_next = 1'b1;
            if ((text_byte & LEAD2_MASK) == LEAD2_TAG) begin
                accum_next = {{(CODE_W-5){1'b0}}, text_byte[4:0]};
                cont_next  = 2'd1;
                emit       = text_last;
            end else if ((text_byte & LEAD3_MASK) == LEAD3_TAG) begin
                accum_next = {{(CODE_W-4){1'b0}}, text_byte[3:0]};
                cont_next  = 2'd2;
                emit       = text_last;
            end else if ((text_byte & LEAD4_MASK) == LEAD4_TAG) begin
                accum_next = {{(CODE_W-3){1'b0}}, text_byte[2:0]};
                cont_next  = 2'd3;
                emit       = text_last;
            end else begin
                // stray continuation or invalid lead
                emit = 1'b1;
            end
        end

        // end of text returns the decoder to its reset state
        if (text_last) begin
            cont_next  = 2'd0;
            accum_next = '0;
            ok_next    = 1'b1;
        end
    end

    assign push = in_fire & emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cont_reg  <= 2'd0;
            accum_reg <= '0;
            ok_reg    <= 1'b1;
        end else if (in_fire) begin
            cont_reg  <= cont_next;
            accum_reg <= accum_next;
            ok_reg    <= ok_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sse_queue.sv =====
// Small work queue between the decoder and the expander.
`timescale 1ns / 1ps
`default_nettype none
module sse_queue #(
    parameter int DEPTH = sse_pkg::QUEUE_DEPTH
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  sse_pkg::sse_job_t    push_job,
    output logic                 full,
    input  wire                  pop,
    output logic                 head_valid,
    output sse_pkg::sse_job_t    head_job
);
    import sse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sse_job_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sse_back.sv =====
// Expander: spells out one queued job as output words, one per cycle while m_ready does not stall it.
`timescale 1ns / 1ps
`default_nettype none
module sse_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  head_valid,
    input  sse_pkg::sse_job_t    head_job,
    output logic                 pop,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [7:0]           m_esc_char,
    output logic                 m_run_last,
    output logic                 m_text_end
);
    import sse_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic [2:0]  end_idx;
    logic [2:0]  digit_pos;
    logic [3:0]  nibble;
    logic [7:0]  cur_char;
    logic        last_byte;
    logic        out_free, emit;

    logic        valid_reg,    valid_next;
    logic [7:0]  char_reg;
    logic        run_last_reg;
    logic        text_end_reg;

    // Index of the job's final output byte
    always_comb begin
        case (head_job.kind)
            JOB_CHAR: end_idx = 3'd0;
            JOB_PAIR: end_idx = 3'd1;
            JOB_CODE: begin
                if (head_job.data > 21'h0FFFFF) begin
                    end_idx = 3'd7;
                end else if (head_job.data > 21'h00FFFF) begin
                    end_idx = 3'd6;
                end else begin
                    end_idx = 3'd5;
                end
            end
            default: end_idx = 3'd0;
        endcase
    end

    // Pick the hex nibble, most significant first
    assign digit_pos = end_idx - idx_reg;
    always_comb begin
        case (digit_pos)
            3'd0: nibble = head_job.data[3:0];
            3'd1: nibble = head_job.data[7:4];
            3'd2: nibble = head_job.data[11:8];
            3'd3: nibble = head_job.data[15:12];
            3'd4: nibble = head_job.data[19:16];
            3'd5: nibble = {3'b000, head_job.data[20]};
            default: nibble = 4'h0;
        endcase
    end

    // Byte for the current position
    always_comb begin
        case (head_job.kind)
            JOB_CHAR: cur_char = head_job.data[7:0];
            JOB_PAIR: cur_char = (idx_reg == 3'd0) ? CH_BSLASH : head_job.data[7:0];
            JOB_CODE: begin
                if (idx_reg == 3'd0) begin
                    cur_char = CH_BSLASH;
                end else if (idx_reg == 3'd1) begin
                    cur_char = CH_U;
                end else begin
                    cur_char = hex_digit(nibble);
                end
            end
            default: cur_char = head_job.data[7:0];
        endcase
    end

    assign out_free  = ~valid_reg | m_ready;
    assign emit      = head_valid & out_free;
    assign last_byte = (idx_reg == end_idx);
    assign pop       = emit & last_byte;

    always_comb begin
        idx_next = idx_reg;
        if (pop) begin
            idx_next = 3'd0;
        end else if (emit) begin
            idx_next = idx_reg + 3'd1;
        end
        valid_next = out_free ? emit : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            char_reg     <= cur_char;
            run_last_reg <= last_byte;
            text_end_reg <= last_byte & head_job.last;
        end
    end

    assign m_valid    = valid_reg;
    assign m_esc_char = char_reg;
    assign m_run_last = run_last_reg;
    assign m_text_end = text_end_reg;

endmodule
`default_nettype wire

// ===== rtl/string_escape_encoder.sv =====
// Top level of the string escape encoder: decoder, work queue and expander.
//
// Usage:
//   Input channel s_*: one raw text byte per word (s_text_byte), with
//   s_text_last on the final byte of a text. Output channel m_*: one byte of
//   the escaped text per word (m_esc_char); m_run_last marks the last byte
//   produced for an input byte, m_text_end the last byte of the whole text.
//   Both channels use valid/ready.
// Throughput: one input byte per cycle while each byte expands to a single output
//   byte and m_ready stays high; an input byte that expands to N bytes (up to 8 for
//   \uXXXXXX) occupies the expander for all of them, one output byte per cycle while m_ready is high.
//   Bytes inside an open UTF-8 sequence produce nothing.
// Path: an accepted input word is written into the work queue, then its first
//   output byte is registered in the expander's output register.
// Stalls: the expander holds its output register while m_ready is low; the
//   decoder keeps accepting until the work queue (QUEUE_DEPTH entries) fills,
//   then drops s_ready.
// Reset: aresetn clears the queue, the output valid flag and the decoder state;
//   no clearing pass is needed, s_ready is high once the queue count is cleared.
`timescale 1ns / 1ps
`default_nettype none
module string_escape_encoder #(
    parameter int QUEUE_DEPTH = sse_pkg::QUEUE_DEPTH
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire [7:0]   s_text_byte,
    input  wire         s_text_last,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_esc_char,
    output logic        m_run_last,
    output logic        m_text_end
);
    import sse_pkg::*;

    sse_job_t  push_job;
    sse_job_t  head_job;
    logic      push, full, pop, head_valid, in_fire;

    assign s_ready = ~full;
    assign in_fire = s_valid & ~full;

    sse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .text_byte (s_text_byte),
        .text_last (s_text_last),
        .push      (push),
        .job       (push_job)
    );

    sse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    sse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_esc_char (m_esc_char),
        .m_run_last (m_run_last),
        .m_text_end (m_text_end)
    );

endmodule
`default_nettype wire

// ===== bench/string_escape_encoder_tb.sv =====
// Self-checking testbench for the string escape encoder: directed table, then random texts.
`timescale 1ns / 1ps
module string_escape_encoder_tb;
    import sse_pkg::*;

    // One word of escaped output.
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       text_end;
    } esc_word_t;

    // One directed row; when typed is set, txt holds the n expected characters.
    typedef struct packed {
        logic [7:0]  b;
        logic        last;
        logic        typed;
        logic [3:0]  n;
        logic [63:0] txt;
    } stim_row_t;

    localparam logic [63:0] QMARK_TXT = 64'("\\u003F");
    localparam int          N_DIRECTED = 25;
    localparam int          N_RANDOM   = 185;

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h41, 1'b0, 1'b1, 4'd1, 64'("A")},          // first byte after reset
        '{8'h00, 1'b0, 1'b1, 4'd2, 64'("\\0")},
        '{8'h07, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h08, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h0C, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h0A, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h0D, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h09, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h0B, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h27, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h22, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h5C, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h7F, 1'b0, 1'b1, 4'd6, 64'("\\u007F")},   // DEL as a control byte
        '{8'h80, 1'b0, 1'b1, 4'd6, QMARK_TXT},         // stray continuation
        '{8'hF7, 1'b0, 1'b1, 4'd0, 64'h0},             // largest 4-byte lead
        '{8'hBF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{8'hBF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{8'hBF, 1'b0, 1'b1, 4'd8, 64'("\\u1FFFFF")},  // no range check on codepoint
        '{8'hE2, 1'b0, 1'b1, 4'd0, 64'h0},
        '{8'h41, 1'b0, 1'b1, 4'd0, 64'h0},             // bad continuation, still open
        '{8'hAC, 1'b0, 1'b1, 4'd6, QMARK_TXT},
        '{8'hC3, 1'b1, 1'b1, 4'd6, QMARK_TXT},         // text cut inside a sequence
        '{8'hFF, 1'b1, 1'b1, 4'd6, QMARK_TXT},         // invalid lead closing a text
        '{8'h01, 1'b0, 1'b0, 4'd0, 64'h0},
        '{8'h7E, 1'b1, 1'b0, 4'd0, 64'h0}
    };

    localparam logic [7:0] SHORT_ESC_SRC [11] = '{
        8'h00, 8'h07, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B, 8'h27, 8'h22, 8'h5C
    };

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'h00;
    logic       s_text_last = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_esc_char;
    logic       m_run_last;
    logic       m_text_end;

    string_escape_encoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .s_text_last (s_text_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_esc_char  (m_esc_char),
        .m_run_last  (m_run_last),
        .m_text_end  (m_text_end)
    );

    always #1 aclk = ~aclk;

    // Decoder state of the predictor
    logic [1:0]  utf_need  = 2'd0;
    logic [20:0] utf_code  = 21'd0;
    logic        utf_clean = 1'b1;

    esc_word_t esc_buf [8];
    int        esc_n;
    esc_word_t pending_esc [$];

    int   mismatches = 0;
    int   bytes_sent = 0;
    int   texts_sent = 0;
    int   words_seen = 0;
    int   seq_count  = 0;
    logic calm       = 1'b0;

    function automatic logic roll_idle();
        return !calm && ($urandom_range(0, 99) < 27);
    endfunction

    function automatic void put_char(input logic [7:0] c);
        esc_buf[esc_n] = '{c, 1'b0, 1'b0};
        esc_n++;
    endfunction

    // \u plus four to six upper-case hex digits
    function automatic void put_code(input logic [20:0] code);
        int         digits;
        logic [3:0] nib;
        digits = (code > 21'hFFFFF) ? 6 : (code > 21'hFFFF) ? 5 : 4;
        put_char(CH_BSLASH);
        put_char(CH_U);
        for (int k = digits - 1; k >= 0; k--) begin
            nib = code[4*k +: 4];
            put_char((nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h37 + {4'h0, nib});
        end
    endfunction

    // Escaped words caused by one text byte, left in esc_buf[0 .. esc_n-1]
    function automatic void escape_byte(input logic [7:0] b, input logic last);
        logic [7:0] letter;
        esc_n = 0;
        if (utf_need != 2'd0) begin
            // every byte of an open sequence counts as a continuation
            if ((b & CONT_MASK) != CONT_TAG) utf_clean = 1'b0;
            utf_code = {utf_code[14:0], b[5:0]};
            utf_need = utf_need - 2'd1;
            if (utf_need == 2'd0) begin
                put_code(utf_clean ? utf_code : QMARK_CODE);
            end else if (last) begin
                put_code(QMARK_CODE);
            end
        end else begin
            case (b)
                8'h00: letter = "0";
                8'h07: letter = "a";
                8'h08: letter = "b";
                8'h0C: letter = "f";
                8'h0A: letter = "n";
                8'h0D: letter = "r";
                8'h09: letter = "t";
                8'h0B: letter = "v";
                8'h27, 8'h22, 8'h5C: letter = b;
                default: letter = 8'h00;
            endcase
            if (letter != 8'h00) begin
                put_char(CH_BSLASH);
                put_char(letter);
            end else if (b >= 8'h20 && b < 8'h7F) begin
                put_char(b);
            end else if (b < 8'h80) begin
                put_code({13'd0, b});
            end else begin
                utf_clean = 1'b1;
                if ((b & LEAD2_MASK) == LEAD2_TAG) begin
                    utf_code = {16'd0, b[4:0]};
                    utf_need = 2'd1;
                end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
                    utf_code = {17'd0, b[3:0]};
                    utf_need = 2'd2;
                end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
                    utf_code = {18'd0, b[2:0]};
                    utf_need = 2'd3;
                end else begin
                    put_code(QMARK_CODE);
                end
                if (utf_need != 2'd0 && last) put_code(QMARK_CODE);
            end
        end
        if (last) begin
            utf_need  = 2'd0;
            utf_code  = 21'd0;
            utf_clean = 1'b1;
        end
        if (esc_n > 0) begin
            esc_buf[esc_n-1].run_last = 1'b1;
            esc_buf[esc_n-1].text_end = last;
        end
    endfunction

    // Offer one byte, starting and ending at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input logic [3:0] n, input logic [63:0] txt);
        int idx;
        while (roll_idle()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_text_last <= last;
        do @(posedge aclk); while (!s_ready);
        escape_byte(b, last);
        if (typed) begin
            for (int k = 0; k < n; k++) begin
                idx = 8 * (int'(n) - 1 - k);
                pending_esc.push_back('{txt[idx +: 8], k == n - 1, last && k == n - 1});
            end
        end else begin
            for (int k = 0; k < esc_n; k++) pending_esc.push_back(esc_buf[k]);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Hold the input off until every expected word has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_esc.size() != 0) @(negedge aclk);
    endtask

    // One random text: mostly well-formed tokens, some broken sequences
    task automatic send_text();
        logic [7:0] text_q [$];
        logic [7:0] lead;
        logic [7:0] cont;
        int         tokens;
        int         kind;
        int         len;
        int         bad;
        int         count;
        tokens = $urandom_range(1, 10);
        for (int t = 0; t < tokens; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (kind < 40) begin
                text_q.push_back(SHORT_ESC_SRC[$urandom_range(0, 10)]);
            end else if (kind < 48) begin
                text_q.push_back((kind < 42) ? 8'h7F : 8'($urandom_range(0, 31)));
            end else if (kind >= 86 && kind < 91) begin
                // invalid lead: stray continuation or 0xF8..0xFF
                text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                      : 8'($urandom_range(8'hF8, 8'hFF)));
            end else begin
                len = (kind < 63) ? 1 : (kind < 76) ? 2 : (kind < 86) ? 3 : $urandom_range(1, 3);
                case (len)
                    1:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                    2:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                    default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                bad   = (kind >= 91 && kind < 96) ? $urandom_range(0, len - 1) : -1;
                count = (kind >= 96) ? $urandom_range(0, len - 1) : len;
                text_q.push_back(lead);
                for (int j = 0; j < count; j++) begin
                    cont = 8'h80 | 8'($urandom_range(0, 63));
                    if (j == bad) begin
                        cont = 8'($urandom_range(0, 255));
                        if (cont[7:6] == 2'b10) cont[6] = 1'b1;
                    end
                    text_q.push_back(cont);
                end
                seq_count++;
                if (kind >= 96) break;  // text ends inside the sequence
            end
        end
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1, 1'b0, 4'd0, 64'h0);
        end
        texts_sent++;
    endtask

    // Output stall pattern
    always @(negedge aclk) begin
        m_ready <= !roll_idle();
    end

    // Compare every accepted output word with the oldest expectation
    always @(posedge aclk) begin
        esc_word_t want;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (pending_esc.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected word %0d: char %h run_last %b text_end %b",
                             words_seen, m_esc_char, m_run_last, m_text_end);
                end
                mismatches++;
            end else begin
                want = pending_esc.pop_front();
                if (want.ch !== m_esc_char || want.run_last !== m_run_last ||
                    want.text_end !== m_text_end) begin
                    if (mismatches < 10) begin
                        $display("word %0d: expected char %h run_last %b text_end %b, got %h %b %b",
                                 words_seen, want.ch, want.run_last, want.text_end,
                                 m_esc_char, m_run_last, m_text_end);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].n, DIRECTED_ROWS[i].txt);
        end
        drain_results();

        while (bytes_sent < N_DIRECTED + N_RANDOM) begin
            // back-to-back stretch in the middle of the random part
            calm = (bytes_sent > N_DIRECTED + 70 && bytes_sent < N_DIRECTED + 130);
            if ($urandom_range(0, 9) == 0) drain_results();
            send_text();
        end
        drain_results();
        repeat (20) @(posedge aclk);

        $display("run covered %0d bytes in %0d texts, %0d UTF-8 sequences, %0d words checked",
                 bytes_sent, texts_sent, seq_count, words_seen);
        $display("mismatching or unexpected words: %0d", mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
